// File: src/sabr_pkg.sv
`timescale 1ns / 1ps

package sabr_pkg;

  localparam int IDX_W       = 10;
  localparam int STORE_DEPTH = 1 << IDX_W;
  localparam int CH_W        = 8;
  localparam int SIDE_W      = 6;
  localparam int POS_W       = 11;
  localparam int FRAME_W     = 11;
  localparam int SCR_W       = 10;
  localparam int ROT_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  localparam int DEF_SPRITE_MAX_SIDE = 32;
  localparam int DEF_FRAME_MAX_SIDE  = 1024;
  localparam int DEF_QUEUE_DEPTH     = 4;

  localparam logic [CH_W-1:0] ALPHA_MAX = 8'd255;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_BLEND = 1'b1;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd6;

  typedef struct packed {
    logic [POS_W-1:0]   sprite_x;
    logic [POS_W-1:0]   sprite_y;
    logic [SIDE_W-1:0]  sprite_width;
    logic [SIDE_W-1:0]  sprite_height;
    logic [ROT_W-1:0]   rotation;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
  } cfg_t;

  // load: idx/rgba is the texel; blend: idx is the texel to fetch, r/g/b the frame colour
  typedef struct packed {
    logic            is_load;
    logic            covered;
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] a;
  } q_entry_t;

endpackage

// File: src/sabr_front.sv
`timescale 1ns / 1ps

module sabr_front #(
  parameter int SPRITE_MAX_SIDE = sabr_pkg::DEF_SPRITE_MAX_SIDE,
  parameter int FRAME_MAX_SIDE  = sabr_pkg::DEF_FRAME_MAX_SIDE
) (
  input  sabr_pkg::cfg_t                      cfg,
  input  logic                                in_mode,
  input  logic [sabr_pkg::IDX_W-1:0]          in_load_index,
  input  logic [sabr_pkg::CH_W-1:0]           in_src_r,
  input  logic [sabr_pkg::CH_W-1:0]           in_src_g,
  input  logic [sabr_pkg::CH_W-1:0]           in_src_b,
  input  logic [sabr_pkg::CH_W-1:0]           in_src_a,
  input  logic [sabr_pkg::SCR_W-1:0]          in_screen_x,
  input  logic [sabr_pkg::SCR_W-1:0]          in_screen_y,
  input  logic [sabr_pkg::CH_W-1:0]           in_dst_r,
  input  logic [sabr_pkg::CH_W-1:0]           in_dst_g,
  input  logic [sabr_pkg::CH_W-1:0]           in_dst_b,
  output sabr_pkg::q_entry_t                  entry
);

  localparam logic [8:0]  SMAX = 9'(SPRITE_MAX_SIDE);
  localparam logic [12:0] FMAX = 13'(FRAME_MAX_SIDE);

  logic [8:0]                   w_sat;
  logic [8:0]                   h_sat;
  logic [sabr_pkg::SIDE_W-1:0]  w;
  logic [sabr_pkg::SIDE_W-1:0]  h;
  logic [sabr_pkg::SIDE_W-1:0]  cw;
  logic [sabr_pkg::SIDE_W-1:0]  ch;
  logic [12:0]                  fw;
  logic [12:0]                  fh;
  logic signed [12:0]           lx;
  logic signed [12:0]           ly;
  logic [sabr_pkg::SIDE_W-1:0]  ux;
  logic [sabr_pkg::SIDE_W-1:0]  uy;
  logic                         hit;
  logic [sabr_pkg::SIDE_W-1:0]  row;
  logic [sabr_pkg::SIDE_W-1:0]  col;
  logic [11:0]                  row_off;
  logic [12:0]                  tex_idx;

  always_comb begin
    w_sat = ({3'b000, cfg.sprite_width} > SMAX) ? SMAX : {3'b000, cfg.sprite_width};
    h_sat = ({3'b000, cfg.sprite_height} > SMAX) ? SMAX : {3'b000, cfg.sprite_height};
    // saturated side never exceeds the register's own range
    w = w_sat[sabr_pkg::SIDE_W-1:0];
    h = h_sat[sabr_pkg::SIDE_W-1:0];
    fw = ({2'b00, cfg.frame_width} > FMAX) ? FMAX : {2'b00, cfg.frame_width};
    fh = ({2'b00, cfg.frame_height} > FMAX) ? FMAX : {2'b00, cfg.frame_height};
    cw = cfg.rotation[0] ? h : w;
    ch = cfg.rotation[0] ? w : h;

    lx = $signed({3'b000, in_screen_x}) - $signed({{2{cfg.sprite_x[10]}}, cfg.sprite_x});
    ly = $signed({3'b000, in_screen_y}) - $signed({{2{cfg.sprite_y[10]}}, cfg.sprite_y});
    ux = lx[sabr_pkg::SIDE_W-1:0];
    uy = ly[sabr_pkg::SIDE_W-1:0];

    hit = ({3'b000, in_screen_x} < fw) && ({3'b000, in_screen_y} < fh) &&
          !lx[12] && !ly[12] &&
          (lx[11:0] < {6'b000000, cw}) && (ly[11:0] < {6'b000000, ch});

    case (cfg.rotation)
      sabr_pkg::ROT_0: begin
        row = uy;
        col = ux;
      end
      sabr_pkg::ROT_90: begin
        row = ux;
        col = w - 6'd1 - uy;
      end
      sabr_pkg::ROT_180: begin
        row = h - 6'd1 - uy;
        col = w - 6'd1 - ux;
      end
      sabr_pkg::ROT_270: begin
        row = h - 6'd1 - ux;
        col = uy;
      end
      default: begin
        row = '0;
        col = '0;
      end
    endcase

    row_off = {6'b000000, row} * {6'b000000, w};
    tex_idx = {1'b0, row_off} + {7'b0000000, col};

    entry.is_load = (in_mode == sabr_pkg::MODE_LOAD);
    if (in_mode == sabr_pkg::MODE_LOAD) begin
      entry.covered = 1'b0;
      entry.idx     = in_load_index;
      entry.r       = in_src_r;
      entry.g       = in_src_g;
      entry.b       = in_src_b;
      entry.a       = in_src_a;
    end else begin
      entry.covered = hit;
      entry.idx     = tex_idx[sabr_pkg::IDX_W-1:0];  // wraps modulo the store depth
      entry.r       = in_dst_r;
      entry.g       = in_dst_g;
      entry.b       = in_dst_b;
      entry.a       = '0;
    end
  end

endmodule

// File: src/sabr_queue.sv
`timescale 1ns / 1ps

module sabr_queue #(
  parameter int DEPTH = sabr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sabr_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output sabr_pkg::q_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sabr_pkg::q_entry_t entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");
`endif

endmodule

// File: src/sabr_back.sv
`timescale 1ns / 1ps

module sabr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  sabr_pkg::q_entry_t          q_entry,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sabr_pkg::CH_W-1:0]   out_r,
  output logic [sabr_pkg::CH_W-1:0]   out_g,
  output logic [sabr_pkg::CH_W-1:0]   out_b,
  output logic                        out_covered
);

  localparam int NCH = 3;

  logic [4*sabr_pkg::CH_W-1:0] mem [sabr_pkg::STORE_DEPTH];
  logic [4*sabr_pkg::CH_W-1:0] rd_data_r;

  logic                           advance;

  logic                           s1_v_r;
  logic                           s1_cov_r;
  logic [NCH-1:0][7:0]            s1_dst_r;

  logic                           s2_v_r;
  logic                           s2_cov_r;
  logic [NCH-1:0][15:0]           s2_ps_r;
  logic [NCH-1:0][15:0]           s2_pd_r;

  logic                           s3_v_r;
  logic                           s3_cov_r;
  logic [NCH-1:0][15:0]           s3_sum_r;
  logic [NCH-1:0][7:0]            s3_qe_r;

  logic                           out_valid_r;
  logic                           out_cov_r;
  logic [NCH-1:0][7:0]            out_ch_r;

  logic [NCH-1:0][7:0]            tex_ch;
  logic [7:0]                     alpha;
  logic [NCH-1:0][7:0]            src_sel;
  logic [NCH-1:0][15:0]           ps_nxt;
  logic [NCH-1:0][15:0]           pd_nxt;
  logic [NCH-1:0][15:0]           sum_nxt;
  logic [NCH-1:0][15:0]           sum_adj;
  logic [NCH-1:0][7:0]            qe_nxt;
  logic [NCH-1:0][15:0]           mul255;
  logic [NCH-1:0][15:0]           rem;
  logic [NCH-1:0][7:0]            out_ch_nxt;

  assign advance = !out_valid_r || out_ready;
  assign q_pop   = q_valid && advance;

  // load and blend both leave the queue in order, so a read always sees earlier loads
  always_ff @(posedge clk) begin
    if (q_pop && q_entry.is_load) begin
      mem[q_entry.idx] <= {q_entry.a, q_entry.b, q_entry.g, q_entry.r};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_entry.is_load) begin
      rd_data_r <= mem[q_entry.idx];
    end
  end

  always_comb begin
    tex_ch[0] = rd_data_r[7:0];
    tex_ch[1] = rd_data_r[15:8];
    tex_ch[2] = rd_data_r[23:16];
    // uncovered pixel: zero alpha makes the mix give back the frame colour
    alpha     = s1_cov_r ? rd_data_r[31:24] : 8'd0;
    for (int i = 0; i < NCH; i++) begin
      src_sel[i] = s1_cov_r ? tex_ch[i] : 8'd0;
      ps_nxt[i]  = {8'd0, src_sel[i]} * {8'd0, alpha};
      pd_nxt[i]  = {8'd0, s1_dst_r[i]} * {8'd0, sabr_pkg::ALPHA_MAX - alpha};
    end
    for (int i = 0; i < NCH; i++) begin
      sum_nxt[i] = s2_ps_r[i] + s2_pd_r[i];
      // divide by 255: estimate is exact or one short
      sum_adj[i] = sum_nxt[i] + {8'd0, sum_nxt[i][15:8]};
      qe_nxt[i]  = sum_adj[i][15:8];
    end
    for (int i = 0; i < NCH; i++) begin
      mul255[i]     = {s3_qe_r[i], 8'd0} - {8'd0, s3_qe_r[i]};
      rem[i]        = s3_sum_r[i] - mul255[i];
      out_ch_nxt[i] = (rem[i] >= 16'd255) ? s3_qe_r[i] + 8'd1 : s3_qe_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_v_r      <= q_pop && !q_entry.is_load;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cov_r    <= q_entry.covered;
      s1_dst_r[0] <= q_entry.r;
      s1_dst_r[1] <= q_entry.g;
      s1_dst_r[2] <= q_entry.b;
      s2_cov_r    <= s1_cov_r;
      s2_ps_r     <= ps_nxt;
      s2_pd_r     <= pd_nxt;
      s3_cov_r    <= s2_cov_r;
      s3_sum_r    <= sum_nxt;
      s3_qe_r     <= qe_nxt;
      out_cov_r   <= s3_cov_r;
      out_ch_r    <= out_ch_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_r       = out_ch_r[0];
  assign out_g       = out_ch_r[1];
  assign out_b       = out_ch_r[2];
  assign out_covered = out_cov_r;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(s1_v_r) && $stable(s2_v_r) && $stable(s3_v_r)))
    else $error("pipeline moved during output stall");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.is_load) |=> !s1_v_r)
    else $error("texel load entered the blend pipeline");
`endif

endmodule

// File: src/sprite_alpha_blit_rotate_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// cfg       cfg_we                 cfg_index, cfg_wdata
// in        in_valid / in_ready    in_mode, in_load_index, in_src_*, in_screen_*, in_dst_*
// out       out_valid / out_ready  out_r, out_g, out_b, out_covered
//
// One item per cycle unless stalled; blend pixels go via the queue and s1-s3 to the output.
// Throughput is set by the single sprite store port: one load or one fetch per cycle.
// A texel load gives no output transfer. A 4-entry queue parts intake from the blend pipeline.
// Output stall freezes the blend pipeline; in_ready drops only once the queue fills.
// Reset is synchronous: registers to defaults, queue and pipeline emptied; the store keeps contents.

module sprite_alpha_blit_rotate_unit #(
  parameter int SPRITE_MAX_SIDE = sabr_pkg::DEF_SPRITE_MAX_SIDE,
  parameter int FRAME_MAX_SIDE  = sabr_pkg::DEF_FRAME_MAX_SIDE,
  parameter int QUEUE_DEPTH     = sabr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               cfg_we,
  input  logic [sabr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sabr_pkg::CFG_DATA_W-1:0]    cfg_wdata,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [sabr_pkg::IDX_W-1:0]         in_load_index,
  input  logic [sabr_pkg::CH_W-1:0]          in_src_r,
  input  logic [sabr_pkg::CH_W-1:0]          in_src_g,
  input  logic [sabr_pkg::CH_W-1:0]          in_src_b,
  input  logic [sabr_pkg::CH_W-1:0]          in_src_a,
  input  logic [sabr_pkg::SCR_W-1:0]         in_screen_x,
  input  logic [sabr_pkg::SCR_W-1:0]         in_screen_y,
  input  logic [sabr_pkg::CH_W-1:0]          in_dst_r,
  input  logic [sabr_pkg::CH_W-1:0]          in_dst_g,
  input  logic [sabr_pkg::CH_W-1:0]          in_dst_b,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sabr_pkg::CH_W-1:0]          out_r,
  output logic [sabr_pkg::CH_W-1:0]          out_g,
  output logic [sabr_pkg::CH_W-1:0]          out_b,
  output logic                               out_covered
);

  sabr_pkg::cfg_t     cfg_r;
  sabr_pkg::q_entry_t front_entry;
  sabr_pkg::q_entry_t q_head;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic               push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sprite_x      <= '0;
      cfg_r.sprite_y      <= '0;
      cfg_r.sprite_width  <= 6'd32;
      cfg_r.sprite_height <= 6'd32;
      cfg_r.rotation      <= sabr_pkg::ROT_0;
      cfg_r.frame_width   <= 11'd1024;
      cfg_r.frame_height  <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        sabr_pkg::CFG_SPRITE_X:      cfg_r.sprite_x      <= cfg_wdata;
        sabr_pkg::CFG_SPRITE_Y:      cfg_r.sprite_y      <= cfg_wdata;
        sabr_pkg::CFG_SPRITE_WIDTH:  cfg_r.sprite_width  <= cfg_wdata[sabr_pkg::SIDE_W-1:0];
        sabr_pkg::CFG_SPRITE_HEIGHT: cfg_r.sprite_height <= cfg_wdata[sabr_pkg::SIDE_W-1:0];
        sabr_pkg::CFG_ROTATION:      cfg_r.rotation      <= cfg_wdata[sabr_pkg::ROT_W-1:0];
        sabr_pkg::CFG_FRAME_WIDTH:   cfg_r.frame_width   <= cfg_wdata;
        sabr_pkg::CFG_FRAME_HEIGHT:  cfg_r.frame_height  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  sabr_front #(
    .SPRITE_MAX_SIDE (SPRITE_MAX_SIDE),
    .FRAME_MAX_SIDE  (FRAME_MAX_SIDE)
  ) u_front (
    .cfg           (cfg_r),
    .in_mode       (in_mode),
    .in_load_index (in_load_index),
    .in_src_r      (in_src_r),
    .in_src_g      (in_src_g),
    .in_src_b      (in_src_b),
    .in_src_a      (in_src_a),
    .in_screen_x   (in_screen_x),
    .in_screen_y   (in_screen_y),
    .in_dst_r      (in_dst_r),
    .in_dst_g      (in_dst_g),
    .in_dst_b      (in_dst_b),
    .entry         (front_entry)
  );

  sabr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  sabr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_entry     (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_r       (out_r),
    .out_g       (out_g),
    .out_b       (out_b),
    .out_covered (out_covered)
  );

endmodule
